[rtl/cau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes, beat structures and helpers of the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DW   = 16;          // data width
	localparam int FB   = 12;          // fraction bits
	localparam int NW   = 2 * DW;      // dividend / divisor / radicand magnitude
	localparam int RW   = NW + DW;     // divider remainder
	localparam int SW   = NW + 2;      // square-root remainder
	localparam int SATW = NW + 2;      // signed width ahead of saturation
	localparam int DS   = DW + 1;      // range check plus one stage per quotient bit

	localparam logic signed [SATW-1:0] SAT_MAX = SATW'(2 ** (DW - 1) - 1);
	localparam logic signed [SATW-1:0] SAT_MIN = SATW'(-(2 ** (DW - 1)));

	typedef enum logic [3:0] {
		FN_ADD   = 4'd0,
		FN_SUB   = 4'd1,
		FN_MUL   = 4'd2,
		FN_CDIV  = 4'd3,
		FN_SCALE = 4'd4,
		FN_RDIV  = 4'd5,
		FN_NEG   = 4'd6,
		FN_CONJ  = 4'd7,
		FN_MAG   = 4'd8
	} func_t;

	// how the back end forms the result
	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_DIV    = 2'd1,
		KIND_SQRT   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          ovf;
		logic          dz;
	} res_t;

	typedef struct packed {
		logic          ovf;
		logic [DW-1:0] val;
	} sat_t;

	// front end to divide / root pipeline
	typedef struct packed {
		res_t          dir;
		kind_t         kind;
		logic          neg_re;
		logic          neg_im;
		logic [NW-1:0] num_re;   // radicand for magnitude
		logic [NW-1:0] num_im;
		logic [NW-1:0] den;
	} pre_t;

	// divide / root pipeline to back end
	typedef struct packed {
		res_t          dir;
		kind_t         kind;
		logic          neg_re;
		logic          neg_im;
		logic [DW-1:0] q_re;
		logic [DW-1:0] q_im;
		logic          big_re;
		logic          big_im;
		logic [DW-1:0] root;
	} post_t;

	function automatic sat_t sat_val(input logic signed [SATW-1:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.ovf = 1'b1;
			r.val = SAT_MAX[DW-1:0];
		end else if (v < SAT_MIN) begin
			r.ovf = 1'b1;
			r.val = SAT_MIN[DW-1:0];
		end else begin
			r.ovf = 1'b0;
			r.val = v[DW-1:0];
		end
		return r;
	endfunction

	function automatic logic [NW-1:0] mag_nw(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] n;
		n = -v;
		return v[SATW-1] ? n[NW-1:0] : v[NW-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/complex_arithmetic_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined signed Q4.12 complex ALU: add, sub, mul, complex divide, scale,
// real divide, negate, conjugate and magnitude, with saturation flags.
// ----------------------------------------------------------------------------
//
//   channel | valid     | stall     | beat contents
//   --------+-----------+-----------+-------------------------------------
//   input   | in_valid  | in_stall  | func, a_re, a_im, b_re, b_im
//   output  | out_valid | out_stall | res_re, res_im, overflow, div_zero
//
// One beat is taken per cycle unless in_stall is high; each result passes
// through the product stage, set-up stage, 17 divider / root stages (range
// check plus one quotient and root bit each) and the output register.
// All stages move together; a stall holds the whole pipe, losing nothing,
// and in_stall rises only while a finished result waits in the output
// register and out_stall is high.
// Reset clears the valid bits only; no clearing pass is needed.
//
module complex_arithmetic_unit_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [3:0]           func,
	input  wire logic signed [15:0]   a_re,
	input  wire logic signed [15:0]   a_im,
	input  wire logic signed [15:0]   b_re,
	input  wire logic signed [15:0]   b_im,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [15:0]        res_re,
	output logic signed [15:0]        res_im,
	output logic                      overflow,
	output logic                      div_zero
);

	logic           adv;       // pipe advances this cycle
	logic           f_vld;
	cau_pkg::pre_t  f_pre;
	logic           i_vld;
	cau_pkg::post_t i_post;

	// the output register can take a new beat when empty or being drained
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	cau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.func    (func),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.out_vld (f_vld),
		.pre_out (f_pre)
	);

	cau_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (f_vld),
		.pre_in   (f_pre),
		.out_vld  (i_vld),
		.post_out (i_post)
	);

	cau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (i_vld),
		.post_in  (i_post),
		.out_vld  (out_valid),
		.res_re   (res_re),
		.res_im   (res_im),
		.overflow (overflow),
		.div_zero (div_zero)
	);

endmodule
`default_nettype wire

[rtl/cau_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Stage 1: operand products. Stage 2: sums, fraction shifts, saturation and
// divider / root operand set-up.
// ----------------------------------------------------------------------------
module cau_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_vld,
	input  wire logic [3:0]            func,
	input  wire logic signed [15:0]    a_re,
	input  wire logic signed [15:0]    a_im,
	input  wire logic signed [15:0]    b_re,
	input  wire logic signed [15:0]    b_im,
	output logic                       out_vld,
	output cau_pkg::pre_t              pre_out
);

	localparam int DW   = cau_pkg::DW;
	localparam int NW   = cau_pkg::NW;
	localparam int SATW = cau_pkg::SATW;

	logic                   vld_s1;
	logic [3:0]             func_s1;
	logic signed [DW-1:0]   ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [NW-1:0]   p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [NW-1:0]   p_aa_s1, p_a2_s1, p_bb_s1, p_b2_s1;

	logic                   vld_s2;
	cau_pkg::pre_t          pre_s2;
	cau_pkg::pre_t          pre_nx;

	logic signed [SATW-1:0] ar_x, ai_x, br_x, bi_x;
	logic signed [SATW-1:0] rr_x, ii_x, ri_x, ir_x;
	logic signed [SATW-1:0] mre, mim, cre, cim;
	logic [NW-1:0]          cden, rden;
	cau_pkg::sat_t          s_re, s_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func;
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_aa_s1 <= a_re * a_re;
			p_a2_s1 <= a_im * a_im;
			p_bb_s1 <= b_re * b_re;
			p_b2_s1 <= b_im * b_im;
			pre_s2  <= pre_nx;
		end
	end

	assign ar_x = SATW'(ar_s1);
	assign ai_x = SATW'(ai_s1);
	assign br_x = SATW'(br_s1);
	assign bi_x = SATW'(bi_s1);
	assign rr_x = SATW'(p_rr_s1);
	assign ii_x = SATW'(p_ii_s1);
	assign ri_x = SATW'(p_ri_s1);
	assign ir_x = SATW'(p_ir_s1);

	assign mre  = rr_x - ii_x;
	assign mim  = ri_x + ir_x;
	assign cre  = rr_x + ii_x;
	assign cim  = ir_x - ri_x;
	assign cden = NW'(p_bb_s1) + NW'(p_b2_s1);
	assign rden = cau_pkg::mag_nw(br_x);

	always_comb begin
		pre_nx = '0;
		s_re   = '0;
		s_im   = '0;
		case (cau_pkg::func_t'(func_s1))
			cau_pkg::FN_ADD: begin
				s_re = cau_pkg::sat_val(ar_x + br_x);
				s_im = cau_pkg::sat_val(ai_x + bi_x);
			end
			cau_pkg::FN_SUB: begin
				s_re = cau_pkg::sat_val(ar_x - br_x);
				s_im = cau_pkg::sat_val(ai_x - bi_x);
			end
			cau_pkg::FN_MUL: begin
				s_re = cau_pkg::sat_val(mre >>> cau_pkg::FB);
				s_im = cau_pkg::sat_val(mim >>> cau_pkg::FB);
			end
			cau_pkg::FN_SCALE: begin
				s_re = cau_pkg::sat_val(rr_x >>> cau_pkg::FB);
				s_im = cau_pkg::sat_val(ir_x >>> cau_pkg::FB);
			end
			cau_pkg::FN_NEG: begin
				s_re = cau_pkg::sat_val(-ar_x);
				s_im = cau_pkg::sat_val(-ai_x);
			end
			cau_pkg::FN_CONJ: begin
				s_re = cau_pkg::sat_val(ar_x);
				s_im = cau_pkg::sat_val(-ai_x);
			end
			cau_pkg::FN_CDIV: begin
				if (cden == '0) begin
					pre_nx.dir.dz = 1'b1;
				end else begin
					pre_nx.kind   = cau_pkg::KIND_DIV;
					pre_nx.neg_re = cre[SATW-1];
					pre_nx.neg_im = cim[SATW-1];
					pre_nx.num_re = cau_pkg::mag_nw(cre);
					pre_nx.num_im = cau_pkg::mag_nw(cim);
					pre_nx.den    = cden;
				end
			end
			cau_pkg::FN_RDIV: begin
				if (br_s1 == '0) begin
					pre_nx.dir.dz = 1'b1;
				end else begin
					pre_nx.kind   = cau_pkg::KIND_DIV;
					pre_nx.neg_re = ar_s1[DW-1] ^ br_s1[DW-1];
					pre_nx.neg_im = ai_s1[DW-1] ^ br_s1[DW-1];
					pre_nx.num_re = cau_pkg::mag_nw(ar_x);
					pre_nx.num_im = cau_pkg::mag_nw(ai_x);
					pre_nx.den    = rden;
				end
			end
			cau_pkg::FN_MAG: begin
				pre_nx.kind   = cau_pkg::KIND_SQRT;
				pre_nx.num_re = NW'(p_aa_s1) + NW'(p_a2_s1);
			end
			default: begin
			end
		endcase
		if (pre_nx.kind == cau_pkg::KIND_DIRECT) begin
			pre_nx.dir.re  = s_re.val;
			pre_nx.dir.im  = s_im.val;
			pre_nx.dir.ovf = s_re.ovf | s_im.ovf;
		end
	end

	assign out_vld = vld_s2;
	assign pre_out = pre_s2;

endmodule
`default_nettype wire

[rtl/cau_iter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_iter
// Pipelined restoring divider (two lanes, shared divisor) and digit-by-digit
// square root: a range check, then one quotient / root bit per stage.
// ----------------------------------------------------------------------------
module cau_iter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_vld,
	input  wire cau_pkg::pre_t  pre_in,
	output logic                out_vld,
	output cau_pkg::post_t      post_out
);

	localparam int DW = cau_pkg::DW;
	localparam int FB = cau_pkg::FB;
	localparam int NW = cau_pkg::NW;
	localparam int RW = cau_pkg::RW;
	localparam int SW = cau_pkg::SW;
	localparam int DS = cau_pkg::DS;

	typedef struct packed {
		cau_pkg::res_t  dir;
		cau_pkg::kind_t kind;
		logic           neg_re;
		logic           neg_im;
		logic [NW-1:0]  den;
		logic [RW-1:0]  rem_re;
		logic [RW-1:0]  rem_im;
		logic [DW-1:0]  q_re;
		logic [DW-1:0]  q_im;
		logic           big_re;
		logic           big_im;
		logic [SW-1:0]  srem;
		logic [DW-1:0]  root;
	} lane_t;

	logic  vld_s [DS];
	lane_t st_s  [DS];
	lane_t nx    [DS];

	// entry: scale dividends, flag quotients that cannot fit in DW bits
	logic [RW-1:0] n0_re, n0_im, dtop;
	assign n0_re = RW'(pre_in.num_re) << FB;
	assign n0_im = RW'(pre_in.num_im) << FB;
	assign dtop  = RW'(pre_in.den) << DW;

	always_comb begin
		nx[0]        = '0;
		nx[0].dir    = pre_in.dir;
		nx[0].kind   = pre_in.kind;
		nx[0].neg_re = pre_in.neg_re;
		nx[0].neg_im = pre_in.neg_im;
		nx[0].den    = pre_in.den;
		nx[0].rem_re = n0_re;
		nx[0].rem_im = n0_im;
		nx[0].big_re = n0_re >= dtop;
		nx[0].big_im = n0_im >= dtop;
		nx[0].srem   = SW'(pre_in.num_re);
	end

	for (genvar k = 1; k < DS; k++) begin : g_bit
		localparam int BI = DW - k;
		logic [RW-1:0] dsh;
		logic [SW-1:0] trial;

		assign dsh   = RW'(st_s[k-1].den) << BI;
		assign trial = (SW'(st_s[k-1].root) << (BI + 1)) + (SW'(1) << (2 * BI));

		always_comb begin
			nx[k] = st_s[k-1];
			if (st_s[k-1].rem_re >= dsh) begin
				nx[k].rem_re   = st_s[k-1].rem_re - dsh;
				nx[k].q_re[BI] = 1'b1;
			end
			if (st_s[k-1].rem_im >= dsh) begin
				nx[k].rem_im   = st_s[k-1].rem_im - dsh;
				nx[k].q_im[BI] = 1'b1;
			end
			if (st_s[k-1].srem >= trial) begin
				nx[k].srem     = st_s[k-1].srem - trial;
				nx[k].root[BI] = 1'b1;
			end
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= (k == 0) ? in_vld : vld_s[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[k] <= nx[k];
			end
		end
	end

	assign out_vld         = vld_s[DS-1];
	assign post_out.dir    = st_s[DS-1].dir;
	assign post_out.kind   = st_s[DS-1].kind;
	assign post_out.neg_re = st_s[DS-1].neg_re;
	assign post_out.neg_im = st_s[DS-1].neg_im;
	assign post_out.q_re   = st_s[DS-1].q_re;
	assign post_out.q_im   = st_s[DS-1].q_im;
	assign post_out.big_re = st_s[DS-1].big_re;
	assign post_out.big_im = st_s[DS-1].big_im;
	assign post_out.root   = st_s[DS-1].root;

endmodule
`default_nettype wire

[rtl/cau_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Signs and saturates quotients and roots, selects the result and holds it
// in the output register.
// ----------------------------------------------------------------------------
module cau_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_vld,
	input  wire cau_pkg::post_t       post_in,
	output logic                      out_vld,
	output logic signed [15:0]        res_re,
	output logic signed [15:0]        res_im,
	output logic                      overflow,
	output logic                      div_zero
);

	localparam int DW = cau_pkg::DW;
	localparam logic [DW-1:0] HALF = {1'b1, {(DW - 1){1'b0}}};

	logic          valid_q;
	cau_pkg::res_t res_q;
	cau_pkg::res_t res_nx;
	cau_pkg::sat_t d_re, d_im;

	function automatic cau_pkg::sat_t div_sat(input logic neg, input logic big,
			input logic [DW-1:0] q);
		cau_pkg::sat_t r;
		if (neg) begin
			r.ovf = big || (q > HALF);
			r.val = r.ovf ? HALF : (~q + DW'(1));
		end else begin
			r.ovf = big || q[DW-1];
			r.val = r.ovf ? ~HALF : q;
		end
		return r;
	endfunction

	assign d_re = div_sat(post_in.neg_re, post_in.big_re, post_in.q_re);
	assign d_im = div_sat(post_in.neg_im, post_in.big_im, post_in.q_im);

	always_comb begin
		res_nx = '0;
		case (post_in.kind)
			cau_pkg::KIND_DIRECT: res_nx = post_in.dir;
			cau_pkg::KIND_DIV: begin
				res_nx.re  = d_re.val;
				res_nx.im  = d_im.val;
				res_nx.ovf = d_re.ovf | d_im.ovf;
			end
			cau_pkg::KIND_SQRT: begin
				res_nx.ovf = post_in.root[DW-1];
				res_nx.re  = post_in.root[DW-1] ? ~HALF : post_in.root;
			end
			default: res_nx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign out_vld  = valid_q;
	assign res_re   = res_q.re;
	assign res_im   = res_q.im;
	assign overflow = res_q.ovf;
	assign div_zero = res_q.dz;

endmodule
`default_nettype wire

[dv/complex_arithmetic_unit_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_tb
// Self-checking bench for the complex ALU: drives operand beats with random
// gaps, predicts each result in fixed point and checks the output in order.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top_tb;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		logic        ovf;
		logic        dz;
	} cplx_res_t;

	localparam logic [3:0] FN_BAD = 4'd9;   // first undefined code
	localparam logic [3:0] FN_BAD_TOP = 4'd15;  // last undefined code
	localparam int LAT = 20;                // beat to result through the whole pipe
	localparam int STUCK_LIMIT = 4000;      // idle cycles before the watchdog fires

	// expected results in issue order, with a mismatch tally
	class alu_scoreboard;
		cplx_res_t pending[$];
		int errors;

		// saturate a signed wide value to 16 bits
		static function logic [15:0] clip(input longint v, inout logic ovf);
			if (v > 32767) begin
				ovf = 1'b1;
				return 16'sh7fff;
			end
			if (v < -32768) begin
				ovf = 1'b1;
				return 16'h8000;
			end
			return v[15:0];
		endfunction

		// floor(num * 2^12 / den), num and den non-negative, capped far out
		static function longint frac_div(input longint num, input longint den);
			longint q;
			q = (num << 12) / den;
			return (q > (longint'(1) << 40)) ? (longint'(1) << 40) : q;
		endfunction

		static function longint int_sqrt(input longint n);
			longint r;
			r = 0;
			for (int b = 31; b >= 0; b--)
				if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
					r = r + (longint'(1) << b);
			return r;
		endfunction

		function void note_beat(input logic [3:0] fn, input logic signed [15:0] ar,
				input logic signed [15:0] ai, input logic signed [15:0] br,
				input logic signed [15:0] bi);
			cplx_res_t e;
			longint x, y, d, ar_l, ai_l, br_l, bi_l;
			ar_l = ar; ai_l = ai; br_l = br; bi_l = bi;
			e = '{re: 16'h0, im: 16'h0, ovf: 1'b0, dz: 1'b0};
			case (fn)
				cau_pkg::FN_ADD: begin
					e.re = clip(ar_l + br_l, e.ovf);
					e.im = clip(ai_l + bi_l, e.ovf);
				end
				cau_pkg::FN_SUB: begin
					e.re = clip(ar_l - br_l, e.ovf);
					e.im = clip(ai_l - bi_l, e.ovf);
				end
				cau_pkg::FN_MUL: begin
					// >>> on a signed product is a floor
					e.re = clip((ar_l * br_l - ai_l * bi_l) >>> 12, e.ovf);
					e.im = clip((ar_l * bi_l + br_l * ai_l) >>> 12, e.ovf);
				end
				cau_pkg::FN_CDIV: begin
					d = br_l * br_l + bi_l * bi_l;
					if (d == 0) e.dz = 1'b1;
					else begin
						// quotients truncate toward zero
						x = ar_l * br_l + ai_l * bi_l;
						y = ai_l * br_l - ar_l * bi_l;
						e.re = clip(x < 0 ? -frac_div(-x, d) : frac_div(x, d), e.ovf);
						e.im = clip(y < 0 ? -frac_div(-y, d) : frac_div(y, d), e.ovf);
					end
				end
				cau_pkg::FN_SCALE: begin
					e.re = clip((ar_l * br_l) >>> 12, e.ovf);
					e.im = clip((ai_l * br_l) >>> 12, e.ovf);
				end
				cau_pkg::FN_RDIV: begin
					if (br_l == 0) e.dz = 1'b1;
					else begin
						d = br_l < 0 ? -br_l : br_l;
						x = frac_div(ar_l < 0 ? -ar_l : ar_l, d);
						y = frac_div(ai_l < 0 ? -ai_l : ai_l, d);
						e.re = clip(((ar_l < 0) != (br_l < 0)) ? -x : x, e.ovf);
						e.im = clip(((ai_l < 0) != (br_l < 0)) ? -y : y, e.ovf);
					end
				end
				cau_pkg::FN_NEG: begin
					e.re = clip(-ar_l, e.ovf);
					e.im = clip(-ai_l, e.ovf);
				end
				cau_pkg::FN_CONJ: begin
					e.re = ar;
					e.im = clip(-ai_l, e.ovf);
				end
				cau_pkg::FN_MAG: e.re = clip(int_sqrt(ar_l * ar_l + ai_l * ai_l), e.ovf);
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		function void check_result(input logic [15:0] re, input logic [15:0] im,
				input logic ovf, input logic dz);
			cplx_res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h %h %b %b", re, im, ovf, dz);
				return;
			end
			e = pending.pop_front();
			if (e.re !== re || e.im !== im || e.ovf !== ovf || e.dz !== dz) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h %h ovf %b dz %b, got %h %h ovf %b dz %b",
						e.re, e.im, e.ovf, e.dz, re, im, ovf, dz);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] func = 4'd0;
	logic signed [15:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] res_re, res_im;
	logic overflow, div_zero;

	alu_scoreboard sb = new();
	bit quiet_tail = 1'b0;      // no idling in the last part
	bit hold_sink = 1'b0;       // request for one long receiver hold-off
	int stuck_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	complex_arithmetic_unit_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_re(res_re), .res_im(res_im), .overflow(overflow), .div_zero(div_zero)
	);

	// accepted beats are sampled at the edge, before the new drive lands
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_beat(func, a_re, a_im, b_re, b_im);
		if (arst_n && out_valid && !out_stall) sb.check_result(res_re, res_im, overflow, div_zero);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) stuck_cycles <= 0;
		else stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles > STUCK_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				out_stall <= 1'b0;
				hold_sink = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	// present one beat and hold it until taken; valid stays high across beats
	task automatic send_beat(input logic [3:0] fn, input logic [15:0] ar,
			input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
		in_valid <= 1'b1;
		func <= fn; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_operand();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 8191)) - 4096);   // between minus one and one
			4: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input bit gaps);
		logic [3:0] fn;
		logic [15:0] br, bi;
		fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		br = rnd_operand();
		bi = rnd_operand();
		// make zero divisors show up often enough
		if ($urandom_range(0, 15) == 0) begin
			br = '0;
			if ($urandom_range(0, 1)) bi = '0;
		end
		send_beat(fn, rnd_operand(), rnd_operand(), br, bi);
		if (gaps && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 14));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation, field extremes, zero divisors, bad codes
		send_beat(cau_pkg::FN_ADD,   16'h7fff, 16'h8000, 16'h0001, 16'hffff);
		send_beat(cau_pkg::FN_SUB,   16'h8000, 16'h7fff, 16'h0001, 16'hffff);
		send_beat(cau_pkg::FN_MUL,   16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_beat(cau_pkg::FN_MUL,   16'hffff, 16'h0001, 16'h0001, 16'hffff);
		send_beat(cau_pkg::FN_CDIV,  16'h1000, 16'h2000, 16'h0000, 16'h0000);
		send_beat(cau_pkg::FN_CDIV,  16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send_beat(cau_pkg::FN_CDIV,  16'h3000, 16'hd000, 16'h1000, 16'hf000);
		send_beat(cau_pkg::FN_SCALE, 16'h7fff, 16'h8000, 16'h8000, 16'h1234);
		send_beat(cau_pkg::FN_RDIV,  16'h1000, 16'hf000, 16'h0000, 16'h5555);
		send_beat(cau_pkg::FN_RDIV,  16'h8000, 16'h7fff, 16'hffff, 16'h0000);
		send_beat(cau_pkg::FN_RDIV,  16'hffff, 16'h0001, 16'h3000, 16'h0000);
		send_beat(cau_pkg::FN_NEG,   16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		send_beat(cau_pkg::FN_CONJ,  16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		send_beat(cau_pkg::FN_MAG,   16'h8000, 16'h8000, 16'h0000, 16'h0000);
		send_beat(cau_pkg::FN_MAG,   16'h0003, 16'hfffc, 16'h0000, 16'h0000);
		send_beat(cau_pkg::FN_MAG,   16'h0000, 16'h0000, 16'hffff, 16'hffff);
		send_beat(FN_BAD,            16'h1111, 16'h2222, 16'h3333, 16'h4444);
		send_beat(FN_BAD_TOP,        16'hffff, 16'hffff, 16'hffff, 16'hffff);

		// random with gaps on both sides
		repeat (500) send_random(1'b1);

		// long receiver hold-off while beats keep coming: the pipe fills
		hold_sink = 1'b1;
		repeat (150) send_random(1'b0);

		// sender pauses until the pipe has drained
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);

		repeat (500) send_random(1'b1);

		// back-to-back tail, no idling on either side
		quiet_tail = 1'b1;
		repeat (180) send_random(1'b0);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
		if (sb.errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_iter.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
dv/complex_arithmetic_unit_top_tb.sv
